/* rtl/actr_pkg.sv */
// ----------------------------------------------------------------------------
// actr_pkg
// shared types, constants and aes helper functions
// ----------------------------------------------------------------------------
package actr_pkg;

  localparam int unsigned BlockW = 128;
  localparam int unsigned WordW  = 64;
  localparam int unsigned Rounds = 10;

  typedef enum logic [0:0] {
    FUNC_ENC = 1'b0,
    FUNC_DEC = 1'b1
  } func_e;

  typedef enum logic [0:0] {
    REG_KEY_HIGH = 1'b0,
    REG_KEY_LOW  = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEYEXP,
    ST_IV,
    ST_ROUND,
    ST_OUT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load_in;     // capture request, start block
    logic key_start;   // load round-0 key from key registers
    logic key_step;    // one key expansion step
    logic iv_emit;     // load zero iv block in output register
    logic ctr_load;    // decrypt start: counter takes data
    logic ctr_clear;   // encrypt start: counter cleared
    logic aes_start;   // increment counter, add round key 0
    logic aes_round;   // one aes round
    logic res_emit;    // result into output register
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic out_busy;    // output register holds a result not yet taken
    logic key_done;    // key schedule complete
    logic round_last;  // final round in progress
  } stat_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[x];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  // next round key; rc is the round constant
  function automatic logic [127:0] key_next(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    t  = sub_word({k[23:0], k[31:24]}) ^ {rc, 24'h0};
    w0 = k[127:96] ^ t;
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    w3 = k[31:0] ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  // one aes round without key addition; byte 0 in bits 127:120
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) b[i] = sbox(s[127 - 8*i -: 8]);
    for (int c = 0; c < 4; c++)
      for (int i = 0; i < 4; i++) t[c*4 + i] = b[((c + i) % 4)*4 + i];
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
        al = a0 ^ a1 ^ a2 ^ a3;
        t[c*4]   = a0 ^ al ^ xtime(a0 ^ a1);
        t[c*4+1] = a1 ^ al ^ xtime(a1 ^ a2);
        t[c*4+2] = a2 ^ al ^ xtime(a2 ^ a3);
        t[c*4+3] = a3 ^ al ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) r[127 - 8*i -: 8] = t[i];
    return r;
  endfunction

endpackage

/* rtl/actr_in_if.sv */
// ----------------------------------------------------------------------------
// actr_in_if
// input request channel
// ----------------------------------------------------------------------------
interface actr_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [63:0] data_high;
  logic [63:0] data_low;
  logic [3:0]  valid_bytes;
  logic        last_in;
  modport source (output valid, func, data_high, data_low, valid_bytes, last_in, input ready);
  modport sink   (input valid, func, data_high, data_low, valid_bytes, last_in, output ready);
endinterface

/* rtl/actr_out_if.sv */
// ----------------------------------------------------------------------------
// actr_out_if
// result request channel
// ----------------------------------------------------------------------------
interface actr_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_high;
  logic [63:0] out_low;
  logic [4:0]  byte_count;
  logic        last_out;
  logic        pad_error;
  modport source (output valid, out_high, out_low, byte_count, last_out, pad_error, input ready);
  modport sink   (input valid, out_high, out_low, byte_count, last_out, pad_error, output ready);
endinterface

/* rtl/aes128_ctr_mode_with_padding.sv */
// ----------------------------------------------------------------------------
// aes128_ctr_mode_with_padding
// aes-128 counter mode over 128-bit blocks with pkcs#7 padding
// ----------------------------------------------------------------------------
// channel   dir  handshake       payload
// in_if     in   valid/ready     func, data_high, data_low, valid_bytes, last_in
// out_if    out  valid/ready     out_high, out_low, byte_count, last_out, pad_error
// cfg       in   cfg_we_i        cfg_idx_i (key_high=0, key_low=1), cfg_data_i
//
// a data block runs capture, ten rounds of the single round unit and output
// load; an encrypt start first emits the zero iv block
// a decrypt start block only loads the counter (no result)
// after reset and after each key write the round keys are rebuilt (key load,
// ten expansion steps, done) before the next request is taken
// a stalled output register holds the sequencer before the next emit
// ----------------------------------------------------------------------------
module aes128_ctr_mode_with_padding (
  input  logic        clk_i,
  input  logic        rst_ni,
  actr_in_if.sink     in_if,
  actr_out_if.source  out_if,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [63:0] cfg_data_i
);

  logic [63:0]     key_high_q, key_low_q;
  actr_pkg::ctrl_t ctrl;
  actr_pkg::stat_t stat;

  // key registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        actr_pkg::REG_KEY_HIGH: key_high_q <= cfg_data_i;
        actr_pkg::REG_KEY_LOW:  key_low_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  actr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_func_i  (in_if.func),
    .in_last_i  (in_if.last_in),
    .key_wr_i   (cfg_we_i),
    .stat_i     (stat),
    .in_ready_o (in_if.ready),
    .ctrl_o     (ctrl)
  );

  actr_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .key_high_i       (key_high_q),
    .key_low_i        (key_low_q),
    .in_func_i        (in_if.func),
    .in_data_high_i   (in_if.data_high),
    .in_data_low_i    (in_if.data_low),
    .in_valid_bytes_i (in_if.valid_bytes),
    .in_last_i        (in_if.last_in),
    .ctrl_i           (ctrl),
    .stat_o           (stat),
    .out_ready_i      (out_if.ready),
    .out_valid_o      (out_if.valid),
    .out_high_o       (out_if.out_high),
    .out_low_o        (out_if.out_low),
    .byte_count_o     (out_if.byte_count),
    .last_out_o       (out_if.last_out),
    .pad_error_o      (out_if.pad_error)
  );

endmodule

/* rtl/actr_ctrl.sv */
// ----------------------------------------------------------------------------
// actr_ctrl
// sequencer for key schedule, iv block and aes rounds
// ----------------------------------------------------------------------------
module actr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_func_i,
  input  logic             in_last_i,
  input  logic             key_wr_i,
  input  actr_pkg::stat_t  stat_i,
  output logic             in_ready_o,
  output actr_pkg::ctrl_t  ctrl_o
);

  actr_pkg::state_e state_q, state_d;
  logic in_msg_q, in_msg_d;
  logic key_dirty_q, key_dirty_d;
  logic accept;

  assign in_ready_o = (state_q == actr_pkg::ST_IDLE) && !key_dirty_q;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      actr_pkg::ST_IDLE: begin
        if (key_dirty_q) begin
          state_d = actr_pkg::ST_KEYEXP;
        end else if (accept) begin
          if (in_func_i == actr_pkg::FUNC_DEC) begin
            state_d = in_msg_q ? actr_pkg::ST_ROUND : actr_pkg::ST_IDLE;
          end else begin
            state_d = in_msg_q ? actr_pkg::ST_ROUND : actr_pkg::ST_IV;
          end
        end
      end
      actr_pkg::ST_KEYEXP: if (stat_i.key_done) state_d = actr_pkg::ST_IDLE;
      actr_pkg::ST_IV:     if (!stat_i.out_busy) state_d = actr_pkg::ST_ROUND;
      actr_pkg::ST_ROUND:  if (stat_i.round_last) state_d = actr_pkg::ST_OUT;
      actr_pkg::ST_OUT:    if (!stat_i.out_busy) state_d = actr_pkg::ST_IDLE;
      default:             state_d = actr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    ctrl_o.load_in = accept;
    unique case (state_q)
      actr_pkg::ST_IDLE: begin
        ctrl_o.key_start = key_dirty_q;
        if (accept) begin
          ctrl_o.ctr_load  = !in_msg_q && (in_func_i == actr_pkg::FUNC_DEC);
          ctrl_o.ctr_clear = !in_msg_q && (in_func_i == actr_pkg::FUNC_ENC);
          ctrl_o.aes_start = in_msg_q;
        end
      end
      actr_pkg::ST_KEYEXP: ctrl_o.key_step = 1'b1;
      actr_pkg::ST_IV: begin
        ctrl_o.iv_emit   = !stat_i.out_busy;
        ctrl_o.aes_start = !stat_i.out_busy;
      end
      actr_pkg::ST_ROUND:  ctrl_o.aes_round = 1'b1;
      actr_pkg::ST_OUT:    ctrl_o.res_emit = !stat_i.out_busy;
      default: ;
    endcase
  end

  always_comb begin
    in_msg_d = in_msg_q;
    if (accept) begin
      in_msg_d = !in_last_i;
    end
    key_dirty_d = key_wr_i ? 1'b1 : (ctrl_o.key_start ? 1'b0 : key_dirty_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= actr_pkg::ST_IDLE;
      in_msg_q    <= 1'b0;
      key_dirty_q <= 1'b1;
    end else begin
      state_q     <= state_d;
      in_msg_q    <= in_msg_d;
      key_dirty_q <= key_dirty_d;
    end
  end

  // a block never starts while the key schedule is stale
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> !key_dirty_q)
    else $error("block accepted with stale key schedule");

  // decrypt start consumes no rounds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.ctr_load |=> state_q == actr_pkg::ST_IDLE)
    else $error("counter load left idle");

  // rounds always end in the output state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == actr_pkg::ST_ROUND && stat_i.round_last) |=> state_q == actr_pkg::ST_OUT)
    else $error("round sequence did not end in output");

  // last block of a message closes it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_last_i) |=> !in_msg_q)
    else $error("message still open after last block");

endmodule

/* rtl/actr_dp.sv */
// ----------------------------------------------------------------------------
// actr_dp
// counter, precomputed key schedule, aes state and output register
// ----------------------------------------------------------------------------
module actr_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [63:0]      key_high_i,
  input  logic [63:0]      key_low_i,
  input  logic             in_func_i,
  input  logic [63:0]      in_data_high_i,
  input  logic [63:0]      in_data_low_i,
  input  logic [3:0]       in_valid_bytes_i,
  input  logic             in_last_i,
  input  actr_pkg::ctrl_t  ctrl_i,
  output actr_pkg::stat_t  stat_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic [63:0]      out_high_o,
  output logic [63:0]      out_low_o,
  output logic [4:0]       byte_count_o,
  output logic             last_out_o,
  output logic             pad_error_o
);

  // round keys kept in a small 11 x 128 bank filled after reset and each key write
  logic [127:0] rk_q [11];
  logic [127:0] kexp_q, kexp_d;
  logic [3:0]   kcnt_q, kcnt_d;
  logic [7:0]   rcon_q, rcon_d;

  logic [127:0] ctr_q, ctr_d;
  logic [127:0] st_q, st_d;
  logic [127:0] blk_q;
  logic         dec_q, last_q;
  logic [3:0]   rnd_q, rnd_d;

  logic         ov_q, ov_d;
  logic [127:0] od_q, od_d;
  logic [4:0]   oc_q, oc_d;
  logic         ol_q, ol_d;
  logic         oe_q, oe_d;

  logic [127:0] ctr_inc, rnd_out, ks_x, padded;
  logic [7:0]   pad_b;
  logic [4:0]   pad_n;
  logic         pad_bad;

  assign ctr_inc = ctr_q + 128'd1;
  assign rnd_out = actr_pkg::aes_round(st_q, rnd_q == 4'(actr_pkg::Rounds)) ^ rk_q[rnd_q];

  // encrypt padding on the captured block
  always_comb begin
    padded = {in_data_high_i, in_data_low_i};
    if (in_last_i && in_func_i == actr_pkg::FUNC_ENC) begin
      for (int i = 0; i < 16; i++)
        if (i >= int'(in_valid_bytes_i))
          padded[127 - 8*i -: 8] = 8'(5'd16 - {1'b0, in_valid_bytes_i});
    end
  end

  assign ks_x    = rnd_out ^ blk_q;
  assign pad_b   = ks_x[7:0];
  assign pad_bad = (pad_b == 8'd0) || (pad_b > 8'd16);
  assign pad_n   = pad_b[4:0];

  assign stat_o.out_busy   = ov_q && !out_ready_i;
  assign stat_o.key_done   = kcnt_q == 4'(actr_pkg::Rounds);
  assign stat_o.round_last = rnd_q == 4'(actr_pkg::Rounds);

  always_comb begin
    kexp_d = kexp_q;
    kcnt_d = kcnt_q;
    rcon_d = rcon_q;
    if (ctrl_i.key_start) begin
      kexp_d = {key_high_i, key_low_i};
      kcnt_d = '0;
      rcon_d = 8'h01;
    end else if (ctrl_i.key_step && kcnt_q != 4'(actr_pkg::Rounds)) begin
      kexp_d = actr_pkg::key_next(kexp_q, rcon_q);
      kcnt_d = kcnt_q + 4'd1;
      rcon_d = actr_pkg::xtime(rcon_q);
    end
  end

  always_comb begin
    ctr_d = ctr_q;
    st_d  = st_q;
    rnd_d = rnd_q;
    if (ctrl_i.ctr_clear) ctr_d = '0;
    if (ctrl_i.ctr_load)  ctr_d = {in_data_high_i, in_data_low_i};
    if (ctrl_i.aes_start) begin
      ctr_d = ctr_inc;
      st_d  = ctr_inc ^ rk_q[0];
      rnd_d = 4'd1;
    end else if (ctrl_i.aes_round && rnd_q != 4'(actr_pkg::Rounds)) begin
      st_d  = rnd_out;
      rnd_d = rnd_q + 4'd1;
    end
  end

  always_comb begin
    ov_d = ov_q && !out_ready_i;
    od_d = od_q;
    oc_d = oc_q;
    ol_d = ol_q;
    oe_d = oe_q;
    if (ctrl_i.iv_emit) begin
      ov_d = 1'b1; od_d = '0; oc_d = 5'd16; ol_d = 1'b0; oe_d = 1'b0;
    end else if (ctrl_i.res_emit) begin
      ov_d = 1'b1;
      od_d = ks_x;
      oc_d = 5'd16;
      ol_d = last_q;
      oe_d = 1'b0;
      if (dec_q && last_q) begin
        if (pad_bad) begin
          oc_d = 5'd0;
          oe_d = 1'b1;
        end else begin
          oc_d = 5'd16 - pad_n;
          for (int i = 0; i < 16; i++)
            if (5'(i) >= 5'd16 - pad_n) od_d[127 - 8*i -: 8] = 8'h00;
        end
      end
    end
  end

  // st_q holds the state before the final round, so rnd_out finishes it in
  // the output state; st_q stays put once the last round index is reached
  always_ff @(posedge clk_i) begin
    if (ctrl_i.key_start || (ctrl_i.key_step && kcnt_q != 4'(actr_pkg::Rounds)))
      rk_q[kcnt_d] <= kexp_d;
    if (ctrl_i.load_in) begin
      blk_q  <= padded;
      dec_q  <= in_func_i;
      last_q <= in_last_i;
    end
    kexp_q <= kexp_d;
    rcon_q <= rcon_d;
    st_q   <= st_d;
    od_q   <= od_d;
    oc_q   <= oc_d;
    ol_q   <= ol_d;
    oe_q   <= oe_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q  <= '0;
      kcnt_q <= '0;
      rnd_q  <= '0;
      ov_q   <= 1'b0;
    end else begin
      ctr_q  <= ctr_d;
      kcnt_q <= kcnt_d;
      rnd_q  <= rnd_d;
      ov_q   <= ov_d;
    end
  end

  assign out_valid_o  = ov_q;
  assign out_high_o   = od_q[127:64];
  assign out_low_o    = od_q[63:0];
  assign byte_count_o = oc_q;
  assign last_out_o   = ol_q;
  assign pad_error_o  = oe_q;

  // emit only into a free output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.iv_emit || ctrl_i.res_emit) |-> !(ov_q && !out_ready_i))
    else $error("result overwrote pending output");

  // a pad error always reports zero bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && oe_q) |-> (oc_q == 5'd0 && ol_q))
    else $error("pad error with nonzero count");

  // counter moves by exactly one per block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.aes_start |=> ctr_q == $past(ctr_q) + 128'd1)
    else $error("counter step wrong");

endmodule
